@@ rtl/gvtl_pkg.sv @@
`default_nettype none
package gvtl_pkg;

  // grid size per axis; cell fields are CELL_W bits wide
  localparam int GRID_NX = 16;
  localparam int GRID_NY = 16;
  localparam int GRID_NZ = 16;
  localparam int CELL_W  = 4;
  localparam int FRAC_W  = 16;
  localparam int QW      = CELL_W + FRAC_W;   // scaled coordinate width
  localparam int PW      = 32 + CELL_W;       // (N-1)*d product width

  // eight parity banks, each holds every other cell along each axis
  localparam int BA_W       = CELL_W - 1;
  localparam int BANK_AW    = 3 * BA_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NBANK      = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_READ_EN,
    REG_X_LO,
    REG_X_HI,
    REG_Y_LO,
    REG_Y_HI,
    REG_Z_LO,
    REG_Z_HI
  } reg_idx_t;

  typedef logic [2:0][31:0] vec3_t;   // [0]=x, [1]=y, [2]=z

  typedef struct packed {
    logic             rd_en;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } cfg_t;

  typedef struct packed {
    logic                   cmd;
    logic [2:0][31:0]       pos;
    logic [2:0][CELL_W-1:0] cidx;
    vec3_t                  val;
  } item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                   cmd;
    logic                   inr;
    logic [2:0][CELL_W-1:0] cidx;
    logic [2:0][FRAC_W-1:0] wt;
    vec3_t                  val;
  } job_t;

  function automatic int grid_n(input int axis);
    case (axis)
      0:       return GRID_NX;
      1:       return GRID_NY;
      default: return GRID_NZ;
    endcase
  endfunction

  // floor((a*(1-w) + b*w)), computed as a + (b-a)*w with an arithmetic shift
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [FRAC_W-1:0] w);
    logic signed [32:0]        diff;
    logic signed [33+FRAC_W:0] prod;
    logic signed [33+FRAC_W:0] acc;
    diff = $signed({b[31], b}) - $signed({a[31], a});
    prod = diff * $signed({1'b0, w});
    acc  = $signed({{2{a[31]}}, a, {FRAC_W{1'b0}}}) + prod;
    return acc[FRAC_W+31:FRAC_W];
  endfunction

endpackage
`default_nettype wire

@@ rtl/gvtl_fifo.sv @@
`default_nettype none
module gvtl_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gvtl_pkg::job_t push_job,
  input  wire logic          pop,
  output gvtl_pkg::job_t     head,
  output logic               full,
  output logic               empty
);
  import gvtl_pkg::*;

  job_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, rp_r;
  logic [FIFO_AW:0]     cnt_r;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");
  a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
                               (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

@@ rtl/gvtl_front.sv @@
`default_nettype none
module gvtl_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gvtl_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire gvtl_pkg::item_t in_item,
  input  wire logic            q_full,
  output logic                 push,
  output gvtl_pkg::job_t       push_job
);
  import gvtl_pkg::*;

  typedef struct packed {
    logic                   cmd;
    logic                   inr;
    logic [2:0][CELL_W-1:0] cidx;
    vec3_t                  val;
  } meta_t;

  typedef struct packed {
    logic               vld;
    meta_t              meta;
    logic [2:0][31:0]   span;
    logic [2:0][31:0]   rem;
    logic [2:0][QW-1:0] nb;
    logic [2:0][QW-1:0] q;
  } div_t;

  logic f_en;

  logic signed [32:0] dd [3];
  logic signed [32:0] sp [3];
  logic               inr;

  logic             s0_vld_r;
  meta_t            s0_meta_r;
  logic [2:0][31:0] s0_d_r, s0_span_r;

  logic             s1_vld_r;
  meta_t            s1_meta_r;
  logic [2:0][31:0] s1_span_r;
  logic [PW-1:0]    s1_prod_r [3];

  div_t dv_r [QW];
  div_t dv_seed;

  // one restoring-division step per axis
  function automatic div_t div_step(input div_t s);
    div_t       r;
    logic [32:0] r2;
    r = s;
    for (int a = 0; a < 3; a++) begin
      r2 = {s.rem[a], s.nb[a][QW-1]};
      if (r2 >= {1'b0, s.span[a]}) begin
        r.rem[a] = 32'(r2 - {1'b0, s.span[a]});
        r.q[a]   = {s.q[a][QW-2:0], 1'b1};
      end else begin
        r.rem[a] = r2[31:0];
        r.q[a]   = {s.q[a][QW-2:0], 1'b0};
      end
      r.nb[a] = {s.nb[a][QW-2:0], 1'b0};
    end
    return r;
  endfunction

  assign f_en     = !q_full;
  assign in_ready = f_en;

  always_comb begin
    inr = cfg.rd_en;
    for (int a = 0; a < 3; a++) begin
      dd[a] = $signed({in_item.pos[a][31], in_item.pos[a]}) -
              $signed({cfg.lo[a][31], cfg.lo[a]});
      sp[a] = $signed({cfg.hi[a][31], cfg.hi[a]}) - $signed({cfg.lo[a][31], cfg.lo[a]});
      if (sp[a] <= 0 || dd[a] < 0 || dd[a] > sp[a]) inr = 1'b0;
    end
  end

  always_comb begin
    dv_seed.vld  = s1_vld_r;
    dv_seed.meta = s1_meta_r;
    dv_seed.span = s1_span_r;
    for (int a = 0; a < 3; a++) begin
      dv_seed.rem[a] = s1_prod_r[a][PW-1:CELL_W];
      dv_seed.nb[a]  = {s1_prod_r[a][CELL_W-1:0], {FRAC_W{1'b0}}};
      dv_seed.q[a]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      for (int i = 0; i < QW; i++) dv_r[i].vld <= 1'b0;
    end else if (f_en) begin
      s0_vld_r       <= in_valid;
      s0_meta_r.cmd  <= in_item.cmd;
      s0_meta_r.inr  <= inr;
      s0_meta_r.cidx <= in_item.cidx;
      s0_meta_r.val  <= in_item.val;
      for (int a = 0; a < 3; a++) begin
        s0_d_r[a]    <= dd[a][31:0];
        s0_span_r[a] <= sp[a][31:0];
      end
      s1_vld_r  <= s0_vld_r;
      s1_meta_r <= s0_meta_r;
      s1_span_r <= s0_span_r;
      for (int a = 0; a < 3; a++) begin
        s1_prod_r[a] <= PW'(s0_d_r[a]) * PW'(grid_n(a) - 1);
      end
      dv_r[0] <= div_step(dv_seed);
      for (int i = 1; i < QW; i++) dv_r[i] <= div_step(dv_r[i-1]);
    end
  end

  always_comb begin
    push          = f_en && dv_r[QW-1].vld;
    push_job.cmd  = dv_r[QW-1].meta.cmd;
    push_job.inr  = dv_r[QW-1].meta.inr;
    push_job.val  = dv_r[QW-1].meta.val;
    for (int a = 0; a < 3; a++) begin
      push_job.cidx[a] = (dv_r[QW-1].meta.cmd == CMD_QUERY) ?
                         dv_r[QW-1].q[a][QW-1:FRAC_W] : dv_r[QW-1].meta.cidx[a];
      push_job.wt[a]   = dv_r[QW-1].q[a][FRAC_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/gvtl_bank.sv @@
`default_nettype none
module gvtl_bank (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [gvtl_pkg::BANK_AW-1:0] waddr,
  input  wire gvtl_pkg::vec3_t       wdata,
  input  wire logic                  re,
  input  wire logic [gvtl_pkg::BANK_AW-1:0] raddr,
  output gvtl_pkg::vec3_t            rdata
);
  import gvtl_pkg::*;

  vec3_t mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/gvtl_back.sv @@
`default_nettype none
module gvtl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gvtl_pkg::job_t head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gvtl_pkg::vec3_t     out_field,
  output logic                out_inr,
  output logic                out_interp
);
  import gvtl_pkg::*;

  logic adv;

  logic                  we   [NBANK];
  logic [BANK_AW-1:0]    ra   [NBANK];
  logic [BANK_AW-1:0]    wa;
  vec3_t                 rd   [NBANK];
  logic                  wr_ok;

  logic                  b1_vld_r;
  job_t                  b1_job_r;
  vec3_t                 corner [NBANK];
  vec3_t                 zb     [4];
  logic                  b1_interp;

  logic                  b2_vld_r, b2_inr_r, b2_interp_r;
  vec3_t                 b2_zb_r [4];
  vec3_t                 b2_floor_r;
  logic [FRAC_W-1:0]     b2_wx_r, b2_wy_r;
  vec3_t                 yb [2];

  logic                  b3_vld_r, b3_inr_r, b3_interp_r;
  vec3_t                 b3_yb_r [2];
  vec3_t                 b3_floor_r;
  logic [FRAC_W-1:0]     b3_wx_r;
  vec3_t                 xb;

  logic                  out_vld_r, out_inr_r, out_interp_r;
  vec3_t                 out_field_r;

  assign adv = !out_vld_r || out_ready;
  assign pop = adv && !q_empty;

  // bank {px,py,pz} holds cells whose coordinate parities match
  always_comb begin
    logic [CELL_W:0] c;
    wr_ok = (int'(head.cidx[0]) < GRID_NX) && (int'(head.cidx[1]) < GRID_NY) &&
            (int'(head.cidx[2]) < GRID_NZ);
    wa = {head.cidx[0][CELL_W-1:1], head.cidx[1][CELL_W-1:1], head.cidx[2][CELL_W-1:1]};
    for (int b = 0; b < NBANK; b++) begin
      we[b] = pop && (head.cmd == CMD_WRITE) && wr_ok &&
              (b[2:0] == {head.cidx[0][0], head.cidx[1][0], head.cidx[2][0]});
      for (int a = 0; a < 3; a++) begin
        // corner offset along this axis that lands in this bank's parity
        c = {1'b0, head.cidx[a]} + (CELL_W+1)'(b[2-a] ^ head.cidx[a][0]);
        ra[b][(2-a)*BA_W +: BA_W] = c[CELL_W-1:1];
      end
    end
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    gvtl_bank u_bank (
      .clk   (clk),
      .we    (we[b]),
      .waddr (wa),
      .wdata (head.val),
      .re    (pop),
      .raddr (ra[b]),
      .rdata (rd[b])
    );
  end

  always_comb begin
    logic [2:0] par;
    par = {b1_job_r.cidx[0][0], b1_job_r.cidx[1][0], b1_job_r.cidx[2][0]};
    b1_interp = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (int'(b1_job_r.cidx[a]) == grid_n(a) - 1) b1_interp = 1'b0;
    end
    for (int d = 0; d < NBANK; d++) corner[d] = rd[d[2:0] ^ par];
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        zb[j][k] = blend(corner[2*j][k], corner[2*j+1][k], b1_job_r.wt[2]);
      end
    end
  end

  always_comb begin
    for (int x = 0; x < 2; x++) begin
      for (int k = 0; k < 3; k++) begin
        yb[x][k] = blend(b2_zb_r[2*x][k], b2_zb_r[2*x+1][k], b2_wy_r);
      end
    end
    for (int k = 0; k < 3; k++) xb[k] = blend(b3_yb_r[0][k], b3_yb_r[1][k], b3_wx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      b3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r    <= pop && (head.cmd == CMD_QUERY);
      b1_job_r    <= head;
      b2_vld_r    <= b1_vld_r;
      b2_inr_r    <= b1_job_r.inr;
      b2_interp_r <= b1_interp;
      b2_zb_r     <= zb;
      b2_floor_r  <= corner[0];
      b2_wx_r     <= b1_job_r.wt[0];
      b2_wy_r     <= b1_job_r.wt[1];
      b3_vld_r    <= b2_vld_r;
      b3_inr_r    <= b2_inr_r;
      b3_interp_r <= b2_interp_r;
      b3_yb_r     <= yb;
      b3_floor_r  <= b2_floor_r;
      b3_wx_r     <= b2_wx_r;
      out_vld_r   <= b3_vld_r;
      out_inr_r   <= b3_inr_r;
      out_interp_r <= b3_inr_r && b3_interp_r;
      if (!b3_inr_r)        out_field_r <= '0;
      else if (b3_interp_r) out_field_r <= xb;
      else                  out_field_r <= b3_floor_r;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_field  = out_field_r;
  assign out_inr    = out_inr_r;
  assign out_interp = out_interp_r;

endmodule
`default_nettype wire

@@ rtl/grid_vector_trilinear_lookup_core.sv @@
`default_nettype none
// Trilinear lookup in a 16x16x16 grid of three-component vectors.
// Input stream: in_tuser is the command (0 = write a cell, 1 = query a position).
//   A write stores value_x/y/z at cell_x/y/z and gives no result item; a query
//   gives exactly one result item on the out_ stream, in input order.
// Result: field_x/y/z on out_tdata, in_range and interpolated on out_tuser.
// Config port: cfg_we/cfg_index/cfg_wdata write read_enable and the six bounds;
//   write only while no items are in flight.
// Pipeline from input accept to result valid: two setup stages,
//   a 20-stage pipelined divider that maps the position to cell and weight,
//   the queue, one bank read, the z and y blend stages, and the x blend
//   landing in the output register.
// Throughput: one item per cycle while not stalled; the eight parity banks
//   give all corners of a query in one read.
// Stall: with a result held and out_tready low, back pipeline and output hold;
//   the front keeps accepting until the 4-deep queue fills, then in_tready drops.
// Reset: control and config are cleared (read disabled, bounds 0..16.0); the
//   grid memory is not cleared and a cell must be written before it is read.
module grid_vector_trilinear_lookup_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, value_x, value_y, value_z, pad
  input  wire logic [207:0] in_tdata,
  // command
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // field_x, field_y, field_z
  output logic [95:0]       out_tdata,
  // in_range, interpolated
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import gvtl_pkg::*;

  cfg_t  cfg_r;
  item_t in_item;
  job_t  push_job, head;
  logic  push, pop, q_full, q_empty;
  vec3_t out_field;
  logic  out_inr, out_interp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rd_en <= 1'b0;
      cfg_r.lo    <= '0;
      cfg_r.hi    <= {3{32'h0010_0000}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_READ_EN: cfg_r.rd_en <= cfg_wdata[0];
        REG_X_LO:    cfg_r.lo[0] <= cfg_wdata;
        REG_X_HI:    cfg_r.hi[0] <= cfg_wdata;
        REG_Y_LO:    cfg_r.lo[1] <= cfg_wdata;
        REG_Y_HI:    cfg_r.hi[1] <= cfg_wdata;
        REG_Z_LO:    cfg_r.lo[2] <= cfg_wdata;
        REG_Z_HI:    cfg_r.hi[2] <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    in_item.cmd     = in_tuser;
    in_item.pos[0]  = in_tdata[31:0];
    in_item.pos[1]  = in_tdata[63:32];
    in_item.pos[2]  = in_tdata[95:64];
    in_item.cidx[0] = in_tdata[99:96];
    in_item.cidx[1] = in_tdata[103:100];
    in_item.cidx[2] = in_tdata[107:104];
    in_item.val[0]  = in_tdata[139:108];
    in_item.val[1]  = in_tdata[171:140];
    in_item.val[2]  = in_tdata[203:172];
  end

  gvtl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  gvtl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  gvtl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_field  (out_field),
    .out_inr    (out_inr),
    .out_interp (out_interp)
  );

  assign out_tdata = out_field;
  assign out_tuser = {out_interp, out_inr};

endmodule
`default_nettype wire
